/* sv/owts_pkg.sv */
`default_nettype none
package owts_pkg;

   localparam int CSR_INDEX_W = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_ROM_ID      = 2'd0,
      REG_TEMPERATURE = 2'd1
   } csr_reg_type;

   localparam logic [7:0] CMD_NONE    = 8'h00;
   localparam logic [7:0] CMD_SEARCH  = 8'hf0;
   localparam logic [7:0] CMD_MATCH   = 8'h55;
   localparam logic [7:0] CMD_SKIP    = 8'hcc;
   localparam logic [7:0] CMD_PSU     = 8'hb4;
   localparam logic [7:0] CMD_CONVERT = 8'h44;
   localparam logic [7:0] CMD_READPAD = 8'hbe;

   localparam logic [15:0] RESET_MIN_US  = 16'd480;
   localparam logic [15:0] WRITE0_MIN_US = 16'd40;
   localparam logic [15:0] SLOT_MIN_US   = 16'd1;

   localparam logic [63:0] PAD_BASE = 64'h1000ff7ff00d0000;

   // q = 2*t/125 via reciprocal: 2^26/125 rounded up, exact for |2t| < 6e6
   localparam logic [19:0] TEMP_RECIP       = 20'd536871;
   localparam int          TEMP_RECIP_SHIFT = 26;
   // scaled value of the reset temperature (85000 mC)
   localparam logic [15:0] TEMP_SCALED_RESET = 16'h0550;

   localparam logic [7:0] CRC_POLY = 8'h8c;

   // Dallas CRC-8, reflected, init 0, bytes LSB first
   function automatic logic [7:0] dallas_crc64(input logic [63:0] v);
      logic [7:0] crc;
      logic       fb;
      crc = 8'h00;
      for (int i = 0; i < 64; i++) begin
         fb  = crc[0] ^ v[i];
         crc = {1'b0, crc[7:1]} ^ (fb ? CRC_POLY : 8'h00);
      end
      return crc;
   endfunction

endpackage
`default_nettype wire

/* sv/owts_pad_gen.sv */
`default_nettype none
module owts_pad_gen
   import owts_pkg::*;
(
   input  wire logic [15:0] temp_scaled,
   output logic      [63:0] pad_word,
   output logic      [7:0]  pad_crc
);

   always_comb begin
      pad_word = {PAD_BASE[63:16], temp_scaled};
      pad_crc  = dallas_crc64(pad_word);
   end

endmodule
`default_nettype wire

/* sv/onewire_temp_sensor_slave_unit.sv */
`default_nettype none
// 1-Wire temperature sensor slave. Each req item is one bus edge: line_level 0 is a falling
// edge and always yields bus_out 1; line_level 1 is a rising edge whose low_time_us selects
// reset/presence (480 us or more), write-0 (over 40 us), or read / write-1 (over 1 us).
// Commands served: search ROM, match ROM (64 bits), skip ROM, read power supply, convert and
// read scratchpad (scaled temperature, fixed bytes, Dallas CRC-8). Every item yields exactly
// one rsp item carrying bus_out. The whole edge decode and command
// step sit between the state registers and the rsp register, so an item is accepted every
// cycle while the rsp side takes its items. Configuration writes are accepted every cycle;
// the temperature is scaled once at write time.
module onewire_temp_sensor_slave_unit
   import owts_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_line_level,
   input  wire logic [15:0]            req_low_time_us,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic                        rsp_bus_out,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [63:0]            csr_data
);

   logic [63:0] rom_id_ff, rom_id_in;
   logic [15:0] temp_scaled_ff, temp_scaled_in;

   logic        drive_level_ff, drive_level_in;
   logic        silenced_ff, silenced_in;
   logic [7:0]  active_command_ff, active_command_in;
   logic [7:0]  rx_shift_ff, rx_shift_in;
   logic [3:0]  rx_bits_ff, rx_bits_in;
   logic [63:0] tx_shift_ff, tx_shift_in;
   logic [6:0]  tx_bits_ff, tx_bits_in;
   logic [6:0]  rom_bit_index_ff, rom_bit_index_in;
   logic [63:0] id_heard_ff, id_heard_in;
   logic [7:0]  pad_crc_ff, pad_crc_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_bus_out_ff, rsp_bus_out_in;

   logic        req_accept;
   logic        csr_accept;

   logic [63:0] pad_word;
   logic [7:0]  pad_crc_calc;

   logic        temp_neg;
   logic [17:0] temp_mag;
   logic [38:0] temp_prod;
   logic [12:0] temp_quo;

   logic        search_go;
   logic        search_bit;
   logic [6:0]  search_prev;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_bus_out = rsp_bus_out_ff;

   owts_pad_gen u_pad_gen (
      .temp_scaled (temp_scaled_ff),
      .pad_word    (pad_word),
      .pad_crc     (pad_crc_calc)
   );

   // temperature scaling: trunc(t * 2 / 125), toward zero
   always_comb begin
      temp_neg  = csr_data[17];
      temp_mag  = temp_neg ? (18'd0 - csr_data[17:0]) : csr_data[17:0];
      temp_prod = {temp_mag, 1'b0} * TEMP_RECIP;
      temp_quo  = temp_prod[TEMP_RECIP_SHIFT +: 13];
   end

   always_comb begin
      rom_id_in      = rom_id_ff;
      temp_scaled_in = temp_scaled_ff;
      if (csr_accept) begin
         case (csr_reg_type'(csr_index))
            REG_ROM_ID: begin
               rom_id_in = csr_data;
            end
            REG_TEMPERATURE: begin
               temp_scaled_in = temp_neg ? (16'd0 - {3'b0, temp_quo}) : {3'b0, temp_quo};
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      drive_level_in    = drive_level_ff;
      silenced_in       = silenced_ff;
      active_command_in = active_command_ff;
      rx_shift_in       = rx_shift_ff;
      rx_bits_in        = rx_bits_ff;
      tx_shift_in       = tx_shift_ff;
      tx_bits_in        = tx_bits_ff;
      rom_bit_index_in  = rom_bit_index_ff;
      id_heard_in       = id_heard_ff;
      pad_crc_in        = pad_crc_ff;
      search_go         = 1'b0;
      search_bit        = 1'b0;
      search_prev       = 7'd0;

      if (req_accept) begin
         if (!req_line_level) begin
            drive_level_in = 1'b1;
         end else begin
            // edge decode
            if (req_low_time_us >= RESET_MIN_US) begin
               active_command_in = CMD_NONE;
               drive_level_in    = 1'b0;
               rx_bits_in        = 4'd0;
               tx_bits_in        = 7'd0;
               rx_shift_in       = 8'd0;
               tx_shift_in       = 64'd0;
               silenced_in       = 1'b0;
            end else if (!silenced_ff) begin
               if (req_low_time_us > WRITE0_MIN_US) begin
                  rx_shift_in = {1'b0, rx_shift_ff[7:1]};
                  rx_bits_in  = rx_bits_ff + 4'd1;
               end else if (req_low_time_us > SLOT_MIN_US) begin
                  if (tx_bits_ff != 7'd0) begin
                     drive_level_in = tx_shift_ff[0];
                     tx_shift_in    = {1'b0, tx_shift_ff[63:1]};
                     tx_bits_in     = tx_bits_ff - 7'd1;
                  end else begin
                     rx_shift_in = {1'b1, rx_shift_ff[7:1]};
                     rx_bits_in  = rx_bits_ff + 4'd1;
                  end
               end
            end

            // full byte: new command
            if (rx_bits_in == 4'd8) begin
               active_command_in = rx_shift_in;
               rx_bits_in        = 4'd0;
               case (rx_shift_in)
                  CMD_SEARCH, CMD_MATCH: begin
                     rom_bit_index_in = 7'd0;
                     tx_bits_in       = 7'd0;
                     id_heard_in      = 64'd0;
                  end
                  CMD_SKIP: begin
                     id_heard_in = rom_id_ff;
                     silenced_in = 1'b0;
                  end
                  CMD_PSU: begin
                     tx_bits_in  = 7'd1;
                     tx_shift_in = 64'd1;
                  end
                  CMD_CONVERT: begin
                     tx_bits_in  = 7'd3;
                     tx_shift_in = 64'd4;
                  end
                  CMD_READPAD: begin
                     tx_bits_in  = 7'd64;
                     tx_shift_in = pad_word;
                     pad_crc_in  = pad_crc_calc;
                  end
                  default: begin
                  end
               endcase
               rx_shift_in = 8'd0;
            end

            // command step
            case (active_command_in)
               CMD_SEARCH: begin
                  if (tx_bits_in == 7'd0 &&
                      (rx_bits_in == 4'd1 || rom_bit_index_in == 7'd0)) begin
                     search_go = 1'b1;
                     if (rx_bits_in != 4'd0) begin
                        search_prev = rom_bit_index_in - 7'd1;
                        id_heard_in = {rx_shift_in[7], id_heard_in[63:1]};
                        if (rx_shift_in[7] != rom_id_ff[search_prev[5:0]]) begin
                           active_command_in = CMD_NONE;
                           silenced_in       = 1'b1;
                           search_go         = 1'b0;
                        end else begin
                           rx_shift_in = 8'd0;
                           rx_bits_in  = 4'd0;
                           if (rom_bit_index_in >= 7'd64) begin
                              active_command_in = CMD_NONE;
                              search_go         = 1'b0;
                           end
                        end
                     end
                     if (search_go) begin
                        search_bit       = rom_id_ff[rom_bit_index_in[5:0]];
                        tx_shift_in      = {62'd0, ~search_bit, search_bit};
                        tx_bits_in       = 7'd2;
                        rom_bit_index_in = rom_bit_index_in + 7'd1;
                     end
                  end
               end
               CMD_MATCH: begin
                  if (rx_bits_in != 4'd0) begin
                     id_heard_in      = {rx_shift_in[7], id_heard_in[63:1]};
                     rx_shift_in      = 8'd0;
                     rx_bits_in       = 4'd0;
                     rom_bit_index_in = rom_bit_index_in + 7'd1;
                     if (rom_bit_index_in >= 7'd64) begin
                        active_command_in = CMD_NONE;
                        silenced_in       = (id_heard_in != rom_id_ff);
                     end
                  end
               end
               CMD_READPAD: begin
                  if (tx_bits_in == 7'd0) begin
                     tx_bits_in        = 7'd8;
                     tx_shift_in       = {56'd0, pad_crc_in};
                     active_command_in = CMD_NONE;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_comb begin
      rsp_bus_out_in = rsp_bus_out_ff;
      if (req_accept) begin
         rsp_valid_in   = 1'b1;
         rsp_bus_out_in = drive_level_in;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_id_ff         <= 64'd0;
         temp_scaled_ff    <= TEMP_SCALED_RESET;
         drive_level_ff    <= 1'b0;
         silenced_ff       <= 1'b0;
         active_command_ff <= CMD_NONE;
         rx_shift_ff       <= 8'd0;
         rx_bits_ff        <= 4'd0;
         tx_shift_ff       <= 64'd0;
         tx_bits_ff        <= 7'd0;
         rom_bit_index_ff  <= 7'd0;
         id_heard_ff       <= 64'd0;
         pad_crc_ff        <= 8'd0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         rom_id_ff         <= rom_id_in;
         temp_scaled_ff    <= temp_scaled_in;
         drive_level_ff    <= drive_level_in;
         silenced_ff       <= silenced_in;
         active_command_ff <= active_command_in;
         rx_shift_ff       <= rx_shift_in;
         rx_bits_ff        <= rx_bits_in;
         tx_shift_ff       <= tx_shift_in;
         tx_bits_ff        <= tx_bits_in;
         rom_bit_index_ff  <= rom_bit_index_in;
         id_heard_ff       <= id_heard_in;
         pad_crc_ff        <= pad_crc_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      rsp_bus_out_ff <= rsp_bus_out_in;
   end

   a_fall_releases: assert property (@(posedge clock) disable iff (reset)
      req_accept && !req_line_level |=> rsp_valid && rsp_bus_out)
      else $error("falling edge item did not release bus");

   a_reset_presence: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_line_level && req_low_time_us >= RESET_MIN_US
      |=> rsp_valid && !rsp_bus_out && !silenced_ff && active_command_ff == CMD_NONE)
      else $error("reset pulse did not give presence");

   a_silenced_idle: assert property (@(posedge clock) disable iff (reset)
      silenced_ff |-> active_command_ff == CMD_NONE)
      else $error("command active while silenced");

   a_rx_bits_range: assert property (@(posedge clock) disable iff (reset)
      rx_bits_ff < 4'd8 && tx_bits_ff <= 7'd64)
      else $error("bit counter out of range");

endmodule
`default_nettype wire
